@@ design/pbmv_pkg.sv @@
// shared constants and types for the pbm p4 stream validator
// phase codes, status codes, header limits and the summary/result structs
// no dependencies
package pbmv_pkg;

  // largest accepted width or height
  localparam int unsigned MaxDim = 512;

  localparam logic [15:0] MinFileBytes = 16'd8;
  localparam logic [15:0] MaxFileBytes = 16'd32779;
  localparam logic [15:0] ByteTotalMax = 16'hFFFF;

  // parser phases
  localparam logic [2:0] PhMag0    = 3'd0;
  localparam logic [2:0] PhMag1    = 3'd1;
  localparam logic [2:0] PhMag2    = 3'd2;
  localparam logic [2:0] PhWidth   = 3'd3;
  localparam logic [2:0] PhHeight  = 3'd4;
  localparam logic [2:0] PhRaster  = 3'd5;
  localparam logic [2:0] PhDiscard = 3'd6;

  // status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StShape = 2'd1;
  localparam logic [1:0] StDims  = 2'd2;
  localparam logic [1:0] StPad   = 2'd3;

  // characters of the header
  localparam logic [7:0] ChP       = 8'h50;
  localparam logic [7:0] ChFour    = 8'h34;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;

  // parser state as it stands after the final byte
  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  header_error;
    logic [15:0] byte_total;
    logic [9:0]  width_value;
    logic [9:0]  height_value;
    logic        padding_bad;
  } pbmv_summary_t;

  typedef struct packed {
    logic [3:0] raster_start;
    logic [6:0] row_byte_count;
    logic [9:0] image_height;
    logic [9:0] image_width;
    logic [1:0] status;
  } pbmv_result_t;

endpackage

@@ design/pbm_p4_stream_validator.sv @@
// top level of the pbm p4 stream validator: header parser, raster padding
// check and one-item result register; depends on pbmv_pkg and pbmv_status
//
//  channel  | direction | payload (lowest bit first)
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | tdata[7:0] data_byte, tlast last_byte
//  m_axis   | out       | tdata status, image_width, image_height,
//           |           |   row_byte_count, raster_start, zero fill to 40 bits
//
// one byte is taken every cycle unless the input side stalls; its effect on the
// parser state lands at the accepting edge, and on the final byte the result
// enters the output register at that same edge. the input side stalls only
// while a result waits and the output side is not ready. reset puts the parser
// at the first magic byte with the output register empty.
module pbm_p4_stream_validator
  import pbmv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] status, [11:2] image_width, [21:12] image_height,
  // [28:22] row_byte_count, [32:29] raster_start, [39:33] zero
  output logic [39:0] m_axis_tdata_o
);

  // parser state
  logic [2:0]  phase_q, phase_d;
  logic [1:0]  digit_q, digit_d;
  logic [9:0]  width_q, width_d;
  logic [9:0]  height_q, height_d;
  logic [15:0] byte_total_q, byte_total_d;
  logic [1:0]  header_error_q, header_error_d;
  logic [5:0]  column_q, column_d;
  logic        padding_bad_q, padding_bad_d;

  // result register
  logic         out_valid_q, out_valid_d;
  pbmv_result_t out_data_q, out_data_d;

  logic          accept;
  logic [9:0]    dim_cur;
  logic [7:0]    delim;
  logic          is_delim;
  logic          bad_digit;
  logic [7:0]    digit_val;
  logic [13:0]   dim_sum;
  logic [9:0]    dim_new;
  logic [10:0]   width_round;
  logic [7:0]    row_bytes;
  logic [7:0]    pad_mask;
  pbmv_summary_t summary;
  pbmv_result_t  result;

  // the output register frees up in the same cycle that its item is taken
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // digit handling shared by the width and height fields
  always_comb begin
    dim_cur   = (phase_q == PhWidth) ? width_q : height_q;
    delim     = (phase_q == PhWidth) ? ChSpace : ChNewline;
    is_delim  = (s_axis_tdata_i == delim) && (digit_q != 2'd0);
    bad_digit = (digit_q == 2'd3) || (s_axis_tdata_i < ChZero) ||
                (s_axis_tdata_i > ChNine) ||
                ((digit_q == 2'd0) && (s_axis_tdata_i == ChZero));
    digit_val = s_axis_tdata_i - ChZero;
    // value times ten plus the new digit, kept to ten bits
    dim_sum   = {1'b0, dim_cur, 3'b000} + {3'b000, dim_cur, 1'b0} + {6'd0, digit_val};
    dim_new   = dim_sum[9:0];
  end

  // raster row geometry from the parsed width
  always_comb begin
    width_round = {1'b0, width_q} + 11'd7;
    row_bytes   = width_round[10:3];
    pad_mask    = (width_q[2:0] == 3'd0) ? 8'h00 : (8'hFF >> width_q[2:0]);
  end

  // next parser state
  always_comb begin
    phase_d        = phase_q;
    digit_d        = digit_q;
    width_d        = width_q;
    height_d       = height_q;
    byte_total_d   = byte_total_q;
    header_error_d = header_error_q;
    column_d       = column_q;
    padding_bad_d  = padding_bad_q;

    if (accept) begin
      if (byte_total_q != ByteTotalMax) begin
        byte_total_d = byte_total_q + 16'd1;
      end

      case (phase_q)
        PhMag0: begin
          if (s_axis_tdata_i == ChP) begin
            phase_d = PhMag1;
          end else begin
            header_error_d = StShape;
            phase_d        = PhDiscard;
          end
        end
        PhMag1: begin
          if (s_axis_tdata_i == ChFour) begin
            phase_d = PhMag2;
          end else begin
            header_error_d = StShape;
            phase_d        = PhDiscard;
          end
        end
        PhMag2: begin
          if (s_axis_tdata_i == ChNewline) begin
            phase_d = PhWidth;
            digit_d = 2'd0;
            width_d = '0;
          end else begin
            header_error_d = StShape;
            phase_d        = PhDiscard;
          end
        end
        PhWidth, PhHeight: begin
          if (is_delim) begin
            digit_d = 2'd0;
            if (phase_q == PhWidth) begin
              phase_d  = PhHeight;
              height_d = '0;
            end else begin
              phase_d  = PhRaster;
              column_d = '0;
            end
          end else if (bad_digit) begin
            header_error_d = StDims;
            phase_d        = PhDiscard;
          end else begin
            if (phase_q == PhWidth) begin
              width_d = dim_new;
            end else begin
              height_d = dim_new;
            end
            if (dim_new > 10'(MaxDim)) begin
              header_error_d = StDims;
              phase_d        = PhDiscard;
            end else begin
              digit_d = digit_q + 2'd1;
            end
          end
        end
        PhRaster: begin
          // last byte of a row carries the padding bits
          if (row_bytes == 8'd0 || ({2'b00, column_q} + 8'd1) >= row_bytes) begin
            if ((s_axis_tdata_i & pad_mask) != 8'h00) begin
              padding_bad_d = 1'b1;
            end
            column_d = '0;
          end else begin
            column_d = column_q + 6'd1;
          end
        end
        default: begin
        end
      endcase
    end

    // decision taken on the state after the final byte
    summary.phase        = phase_d;
    summary.header_error = header_error_d;
    summary.byte_total   = byte_total_d;
    summary.width_value  = width_d;
    summary.height_value = height_d;
    summary.padding_bad  = padding_bad_d;

    // back to the start of a file after the final byte
    if (accept && s_axis_tlast_i) begin
      phase_d        = PhMag0;
      digit_d        = '0;
      width_d        = '0;
      height_d       = '0;
      byte_total_d   = '0;
      header_error_d = StOk;
      column_d       = '0;
      padding_bad_d  = 1'b0;
    end
  end

  pbmv_status u_status (
    .summary_i (summary),
    .result_o  (result)
  );

  // result register: loaded on the final byte, emptied when taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (accept && s_axis_tlast_i) begin
      out_valid_d = 1'b1;
      out_data_d  = result;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhMag0;
      digit_q        <= '0;
      width_q        <= '0;
      height_q       <= '0;
      byte_total_q   <= '0;
      header_error_q <= StOk;
      column_q       <= '0;
      padding_bad_q  <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      digit_q        <= digit_d;
      width_q        <= width_d;
      height_q       <= height_d;
      byte_total_q   <= byte_total_d;
      header_error_q <= header_error_d;
      column_q       <= column_d;
      padding_bad_q  <= padding_bad_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // payload register needs no reset
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_data_q};

endmodule

@@ design/pbmv_status.sv @@
// end-of-file status decision for the pbm p4 stream validator
// depends on pbmv_pkg for status codes, size limits and the structs
module pbmv_status
  import pbmv_pkg::*;
(
  input  pbmv_summary_t summary_i,
  output pbmv_result_t  result_o
);

  logic [1:0]  width_digits;
  logic [1:0]  height_digits;
  logic [3:0]  start;
  logic [10:0] width_round;
  logic [7:0]  row_bytes;
  logic [17:0] raster_bytes;
  logic [17:0] expected_total;
  logic [1:0]  status;

  always_comb begin
    width_digits  = (summary_i.width_value < 10'd10)  ? 2'd1 :
                    (summary_i.width_value < 10'd100) ? 2'd2 : 2'd3;
    height_digits = (summary_i.height_value < 10'd10)  ? 2'd1 :
                    (summary_i.height_value < 10'd100) ? 2'd2 : 2'd3;
    start          = 4'd5 + {2'b00, width_digits} + {2'b00, height_digits};
    width_round    = {1'b0, summary_i.width_value} + 11'd7;
    row_bytes      = width_round[10:3];
    raster_bytes   = row_bytes * summary_i.height_value;
    expected_total = raster_bytes + {14'd0, start};

    if (summary_i.byte_total < MinFileBytes || summary_i.byte_total > MaxFileBytes) begin
      status = StShape;
    end else if (summary_i.header_error != StOk) begin
      status = summary_i.header_error;
    end else if (summary_i.phase != PhRaster) begin
      status = StShape;
    end else if ({2'b00, summary_i.byte_total} != expected_total) begin
      status = StShape;
    end else if (summary_i.padding_bad) begin
      status = StPad;
    end else begin
      status = StOk;
    end

    result_o.status = status;
    if (status == StOk) begin
      result_o.image_width    = summary_i.width_value;
      result_o.image_height   = summary_i.height_value;
      result_o.row_byte_count = row_bytes[6:0];
      result_o.raster_start   = start;
    end else begin
      result_o.image_width    = '0;
      result_o.image_height   = '0;
      result_o.row_byte_count = '0;
      result_o.raster_start   = '0;
    end
  end

endmodule
